// ===== sv/scal_pkg.sv =====
package scal_pkg;

    localparam int NUM_SENSORS_DEF = 10;
    localparam int AVG_SENSORS_DEF = 8;

    localparam logic [15:0] TEMP_NEG_MIN = 16'hFF38;
    localparam logic [15:0] TEMP_POS_MAX = 16'h0320;
    localparam logic [15:0] HUMI_MAX     = 16'h03E8;
    localparam logic signed [15:0] GAIN_ONE = 16'sd4096;

    // Divider operand widths: a fit dividend is |dy|*4096 + |dx|/2.
    localparam int DVD_W = 30;
    localparam int DVS_W = 17;

    localparam logic [2:0] SLOT_ACTION = 3'd4;

    localparam logic [15:0] ACT_FIT_T = 16'd1;
    localparam logic [15:0] ACT_FIT_H = 16'd2;
    localparam logic [15:0] ACT_RST_T = 16'd3;
    localparam logic [15:0] ACT_RST_H = 16'd4;

    localparam logic [4:0] GROUP_BASE = 5'd6;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_REJECT = 2'd2,
        ST_NONE   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_T,
        S_MUL_H,
        S_CAL_H,
        S_SUM,
        S_DIV,
        S_DIV_WAIT,
        S_RD1,
        S_RD2,
        S_FIT,
        S_MUL_O,
        S_OFF,
        S_OUT
    } state_t;

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        logic signed [15:0] r;
        if (v > 36'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -36'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Rounds a Q12 product to an integer, ties toward plus infinity.
    function automatic logic signed [21:0] round_q12(input logic signed [32:0] p);
        logic signed [33:0] t;
        t = 34'(p) + 34'sd2048;
        return t[33:12];
    endfunction

    // Address divided by five through a reciprocal; exact for seven bits.
    function automatic logic [4:0] div5(input logic [6:0] a);
        logic [14:0] p;
        p = 15'(a) * 15'd205;
        return p[14:10];
    endfunction

endpackage

// ===== sv/scal_mul.sv =====
module scal_mul (
    input  logic                clk,
    input  logic signed [15:0]  a,
    input  logic signed [16:0]  b,
    output logic signed [32:0]  p
);

    logic signed [32:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 33'(a) * 33'(b);
    end

    assign p = p_reg;

endmodule

// ===== sv/scal_div.sv =====
module scal_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [scal_pkg::DVD_W-1:0]  dividend,
    input  logic [scal_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [scal_pkg::DVD_W-1:0]  quotient
);

    localparam int CW = $clog2(scal_pkg::DVD_W + 1);

    logic [CW-1:0]               cnt_reg;
    logic                        done_reg;
    logic [scal_pkg::DVD_W-1:0]  q_reg;
    logic [scal_pkg::DVS_W-1:0]  rem_reg;
    logic [scal_pkg::DVS_W-1:0]  dvs_reg;
    logic [scal_pkg::DVS_W:0]    trial;
    logic                        fits;

    assign trial = {rem_reg, q_reg[scal_pkg::DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CW'(scal_pkg::DVD_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle, restoring form.
    always_ff @(posedge clk)
    begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            if (fits) begin
                rem_reg <= scal_pkg::DVS_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_reg <= trial[scal_pkg::DVS_W-1:0];
            end
            q_reg <= {q_reg[scal_pkg::DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== sv/sensor_two_point_calibrator.sv =====
// Two-point linear calibration for a set of temperature and humidity sensors.
// Input channel (in_valid/in_stall) carries either a sensor reading or a
// calibration register write; each accepted transfer yields exactly one
// result transfer on the output channel (out_valid/out_stall).
// One item is handled at a time: in_stall is high from acceptance until the
// result transfer completes.
// Sequence after acceptance: an in-range reading goes from DECODE through
// MUL_T, MUL_H and CAL_H to OUT; an out-of-range reading, a reading of an
// unknown sensor and any write other than a gain fit go from DECODE to OUT.
// A reading of the averaging sensor with a nonzero reading count also sums
// the averaged sensors and runs two divisions. A gain fit reads both
// points, runs the bit-serial divider producing one quotient bit per cycle
// and then the offset multiply, skipped when the gain overflows; equal X
// points are rejected before the division.
// At reset all gains are 1.0, offsets, stored raw values, calibrated values
// and the reading count are zero, and all reference points read as zero.
// When the receiver stalls, the result holds on the output ports and no
// new item is accepted.
module sensor_two_point_calibrator #(
    parameter int NUM_SENSORS = scal_pkg::NUM_SENSORS_DEF,
    parameter int AVG_SENSORS = scal_pkg::AVG_SENSORS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [3:0]          sensor_index,
    input  logic [15:0]         raw_temp,
    input  logic [15:0]         raw_humi,
    input  logic [6:0]          register_address,
    input  logic [15:0]         register_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          sensor_number,
    output logic [1:0]          status,
    output logic signed [15:0]  temp_value,
    output logic signed [15:0]  humi_value,
    output logic                average_valid,
    output logic signed [15:0]  average_temp,
    output logic signed [15:0]  average_humi
);

    localparam int IW      = $clog2(NUM_SENSORS);
    localparam int AW      = IW + 2;
    localparam int DEPTH   = 4 * NUM_SENSORS;
    localparam int AVG_CNT = (AVG_SENSORS < NUM_SENSORS) ? AVG_SENSORS : NUM_SENSORS;
    localparam int SUM_W   = 17 + $clog2(AVG_SENSORS);
    localparam int DW      = scal_pkg::DVD_W;

    scal_pkg::state_t  state_reg, state_next;

    logic              cmd_reg;
    logic [3:0]        sidx_reg;
    logic [IW-1:0]     id_reg;
    logic [15:0]       rt_reg, rh_reg, val_reg;
    logic [2:0]        slot_reg;
    logic              cfg_ok_reg;
    logic              acth_reg;
    logic              hum_reg;

    logic signed [15:0] tgain_reg [NUM_SENSORS];
    logic signed [15:0] toff_reg  [NUM_SENSORS];
    logic signed [15:0] hgain_reg [NUM_SENSORS];
    logic signed [15:0] hoff_reg  [NUM_SENSORS];
    logic [15:0]        lastt_reg [NUM_SENSORS];
    logic [15:0]        lasth_reg [NUM_SENSORS];
    logic signed [15:0] calt_reg  [NUM_SENSORS];
    logic signed [15:0] calh_reg  [NUM_SENSORS];
    logic               bad_reg   [NUM_SENSORS];
    logic [3:0]         count_reg;

    logic signed [SUM_W-1:0] sumt_reg, sumh_reg;
    logic [IW-1:0]           i_reg;

    logic [31:0]       p1_reg;
    logic [DW-1:0]     fdvd_reg;
    logic [16:0]       fdvs_reg;
    logic              fneg_reg;
    logic signed [15:0] gq_reg;

    logic [3:0]        num_reg;
    scal_pkg::status_t status_reg;
    logic signed [15:0] tv_reg, hv_reg, at_reg, ah_reg;
    logic              av_reg;

    logic [31:0]       mem [DEPTH];
    logic              mv_reg [DEPTH];
    logic [31:0]       rd_q_reg;
    logic              rd_v_reg;

    // Decode of the incoming address.
    logic [4:0]        grp;
    logic [6:0]        slot_full;
    logic [4:0]        cfg_id;

    assign grp       = scal_pkg::div5(register_address);
    assign slot_full = register_address - 7'(grp) * 7'd5;
    assign cfg_id    = grp - scal_pkg::GROUP_BASE;

    logic [IW-1:0]     rd_idx;
    logic              tok, hok, sidx_ok, is_avg, below_avg, avg_go;
    logic [31:0]       mem_word;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              mem_we;
    logic [15:0]       x_sel;

    assign rd_idx    = (state_reg == scal_pkg::S_SUM) ? i_reg : id_reg;
    assign tok       = (rt_reg >= scal_pkg::TEMP_NEG_MIN) || (rt_reg <= scal_pkg::TEMP_POS_MAX);
    assign hok       = rh_reg <= scal_pkg::HUMI_MAX;
    assign sidx_ok   = {1'b0, sidx_reg} < 5'(NUM_SENSORS);
    assign is_avg    = {1'b0, sidx_reg} == 5'(AVG_SENSORS);
    assign below_avg = {1'b0, sidx_reg} < 5'(AVG_SENSORS);
    assign avg_go    = is_avg && (count_reg != 4'd0);
    assign mem_word  = rd_v_reg ? rd_q_reg : 32'd0;
    assign rd_addr   = {id_reg, acth_reg, state_reg == scal_pkg::S_RD2};
    assign wr_addr   = {id_reg, slot_reg[1:0]};
    assign x_sel     = (slot_reg < 3'd2) ? lastt_reg[rd_idx] : lasth_reg[rd_idx];
    assign mem_we    = (state_reg == scal_pkg::S_DECODE) && cmd_reg && cfg_ok_reg
                       && (slot_reg != scal_pkg::SLOT_ACTION);

    // Shared multiplier and divider.
    logic signed [15:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [32:0] mul_p;
    logic               div_start;
    logic [DW-1:0]      div_dvd;
    logic [16:0]        div_dvs;
    logic               div_done;
    logic [DW-1:0]      div_q;

    scal_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    scal_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // Fit operands from the two reference points.
    logic signed [16:0] fit_dy, fit_dx;
    logic signed [28:0] fit_num;
    logic [28:0]        fit_an;
    logic [16:0]        fit_ad;
    logic               fit_eq;

    assign fit_dy  = 17'($signed(mem_word[15:0])) - 17'($signed(p1_reg[15:0]));
    assign fit_dx  = 17'($signed(mem_word[31:16])) - 17'($signed(p1_reg[31:16]));
    assign fit_num = {fit_dy, 12'd0};
    assign fit_an  = fit_num[28] ? 29'(-fit_num) : 29'(fit_num);
    assign fit_ad  = fit_dx[16] ? 17'(-fit_dx) : 17'(fit_dx);
    assign fit_eq  = mem_word[31:16] == p1_reg[31:16];

    // Quotient post-processing.
    logic signed [SUM_W-1:0] sum_sel;
    logic signed [DW-1:0]    sum_ext;
    logic signed [35:0]      q_signed;
    logic signed [15:0]      avg_val;
    logic                    gain_ovf;
    logic signed [15:0]      gain_val;
    logic signed [15:0]      cal_val;
    logic signed [15:0]      off_val;
    logic signed [15:0]      off_sel;

    assign sum_sel  = hum_reg ? sumh_reg : sumt_reg;
    assign sum_ext  = DW'(sum_sel);
    assign q_signed = sum_sel[SUM_W-1] ? -$signed({6'd0, div_q}) : $signed({6'd0, div_q});
    assign avg_val  = scal_pkg::sat16(q_signed);
    assign gain_ovf = fneg_reg ? (div_q > DW'(32768)) : (div_q > DW'(32767));
    assign gain_val = fneg_reg ? -$signed(div_q[15:0]) : $signed(div_q[15:0]);
    assign off_sel  = (state_reg == scal_pkg::S_MUL_H) ? toff_reg[rd_idx] : hoff_reg[rd_idx];
    assign cal_val  = scal_pkg::sat16(36'(scal_pkg::round_q12(mul_p)) + 36'(off_sel));
    assign off_val  = scal_pkg::sat16(36'($signed(p1_reg[15:0]))
                                      - 36'(scal_pkg::round_q12(mul_p)));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scal_pkg::S_IDLE: begin
                if (in_valid) begin
                    state_next = scal_pkg::S_DECODE;
                end
            end
            scal_pkg::S_DECODE: begin
                if (!cmd_reg) begin
                    if (!sidx_ok) begin
                        state_next = scal_pkg::S_OUT;
                    end else if (tok && hok) begin
                        state_next = scal_pkg::S_MUL_T;
                    end else if (avg_go) begin
                        state_next = scal_pkg::S_SUM;
                    end else begin
                        state_next = scal_pkg::S_OUT;
                    end
                end else if (cfg_ok_reg && slot_reg == scal_pkg::SLOT_ACTION
                             && (val_reg == scal_pkg::ACT_FIT_T
                                 || val_reg == scal_pkg::ACT_FIT_H)) begin
                    state_next = scal_pkg::S_RD1;
                end else begin
                    state_next = scal_pkg::S_OUT;
                end
            end
            scal_pkg::S_MUL_T: state_next = scal_pkg::S_MUL_H;
            scal_pkg::S_MUL_H: state_next = scal_pkg::S_CAL_H;
            scal_pkg::S_CAL_H: state_next = avg_go ? scal_pkg::S_SUM : scal_pkg::S_OUT;
            scal_pkg::S_SUM: begin
                if (i_reg == IW'(AVG_CNT - 1)) begin
                    state_next = scal_pkg::S_DIV;
                end
            end
            scal_pkg::S_DIV: state_next = scal_pkg::S_DIV_WAIT;
            scal_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    if (cmd_reg) begin
                        state_next = gain_ovf ? scal_pkg::S_OUT : scal_pkg::S_MUL_O;
                    end else begin
                        state_next = hum_reg ? scal_pkg::S_OUT : scal_pkg::S_DIV;
                    end
                end
            end
            scal_pkg::S_RD1: state_next = scal_pkg::S_RD2;
            scal_pkg::S_RD2: state_next = scal_pkg::S_FIT;
            scal_pkg::S_FIT: state_next = fit_eq ? scal_pkg::S_OUT : scal_pkg::S_DIV;
            scal_pkg::S_MUL_O: state_next = scal_pkg::S_OFF;
            scal_pkg::S_OFF: state_next = scal_pkg::S_OUT;
            scal_pkg::S_OUT: begin
                if (!out_stall) begin
                    state_next = scal_pkg::S_IDLE;
                end
            end
            default: state_next = scal_pkg::S_IDLE;
        endcase
    end

    // Control outputs and shared unit operands.
    always_comb
    begin
        in_stall  = state_reg != scal_pkg::S_IDLE;
        out_valid = state_reg == scal_pkg::S_OUT;
        div_start = state_reg == scal_pkg::S_DIV;
        mul_a     = tgain_reg[rd_idx];
        mul_b     = {rt_reg[15], rt_reg};
        unique case (state_reg)
            scal_pkg::S_MUL_H: begin
                mul_a = hgain_reg[rd_idx];
                mul_b = {1'b0, rh_reg};
            end
            scal_pkg::S_MUL_O: begin
                mul_a = gq_reg;
                mul_b = {p1_reg[31], p1_reg[31:16]};
            end
            default: begin
                mul_a = tgain_reg[rd_idx];
                mul_b = {rt_reg[15], rt_reg};
            end
        endcase
        if (cmd_reg) begin
            div_dvd = fdvd_reg;
            div_dvs = fdvs_reg;
        end else begin
            div_dvd = sum_sel[SUM_W-1] ? DW'(-sum_ext) : DW'(sum_ext);
            div_dvs = 17'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= scal_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Per-sensor state and sequencing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < NUM_SENSORS; k++) begin
                tgain_reg[k] <= scal_pkg::GAIN_ONE;
                hgain_reg[k] <= scal_pkg::GAIN_ONE;
                toff_reg[k]  <= '0;
                hoff_reg[k]  <= '0;
                lastt_reg[k] <= '0;
                lasth_reg[k] <= '0;
                calt_reg[k]  <= '0;
                calh_reg[k]  <= '0;
                bad_reg[k]   <= 1'b0;
            end
            for (int k = 0; k < DEPTH; k++) begin
                mv_reg[k] <= 1'b0;
            end
            count_reg  <= '0;
            status_reg <= scal_pkg::ST_NONE;
            av_reg     <= 1'b0;
            hum_reg    <= 1'b0;
            acth_reg   <= 1'b0;
            cmd_reg    <= 1'b0;
            cfg_ok_reg <= 1'b0;
            slot_reg   <= '0;
            i_reg      <= '0;
        end else begin
            unique case (state_reg)
                scal_pkg::S_IDLE: begin
                    if (in_valid) begin
                        cmd_reg    <= command;
                        slot_reg   <= slot_full[2:0];
                        cfg_ok_reg <= (grp >= scal_pkg::GROUP_BASE)
                                      && (cfg_id < 5'(NUM_SENSORS));
                        acth_reg   <= register_value == scal_pkg::ACT_FIT_H;
                        status_reg <= scal_pkg::ST_NONE;
                        av_reg     <= 1'b0;
                        hum_reg    <= 1'b0;
                    end
                end
                scal_pkg::S_DECODE: begin
                    i_reg <= '0;
                    if (!cmd_reg) begin
                        if (sidx_ok) begin
                            if (tok) begin
                                lastt_reg[id_reg] <= rt_reg;
                            end
                            if (tok && hok) begin
                                lasth_reg[id_reg] <= rh_reg;
                                bad_reg[id_reg]   <= 1'b0;
                            end else begin
                                bad_reg[id_reg] <= 1'b1;
                                status_reg      <= scal_pkg::ST_RANGE;
                            end
                            if (below_avg && count_reg != 4'd15) begin
                                count_reg <= count_reg + 4'd1;
                            end
                        end
                    end else if (cfg_ok_reg) begin
                        if (slot_reg != scal_pkg::SLOT_ACTION) begin
                            mv_reg[wr_addr] <= 1'b1;
                            status_reg      <= scal_pkg::ST_OK;
                        end else begin
                            case (val_reg)
                                scal_pkg::ACT_RST_T: begin
                                    tgain_reg[id_reg] <= scal_pkg::GAIN_ONE;
                                    toff_reg[id_reg]  <= '0;
                                    status_reg        <= scal_pkg::ST_OK;
                                end
                                scal_pkg::ACT_RST_H: begin
                                    hgain_reg[id_reg] <= scal_pkg::GAIN_ONE;
                                    hoff_reg[id_reg]  <= '0;
                                    status_reg        <= scal_pkg::ST_OK;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                scal_pkg::S_CAL_H: begin
                    calt_reg[id_reg] <= tv_reg;
                    calh_reg[id_reg] <= cal_val;
                    status_reg       <= scal_pkg::ST_OK;
                end
                scal_pkg::S_SUM: begin
                    i_reg <= i_reg + 1'b1;
                end
                scal_pkg::S_DIV_WAIT: begin
                    if (div_done) begin
                        if (cmd_reg) begin
                            if (gain_ovf) begin
                                status_reg <= scal_pkg::ST_REJECT;
                            end
                        end else if (hum_reg) begin
                            av_reg    <= 1'b1;
                            count_reg <= '0;
                        end else begin
                            hum_reg <= 1'b1;
                        end
                    end
                end
                scal_pkg::S_FIT: begin
                    if (fit_eq) begin
                        status_reg <= scal_pkg::ST_REJECT;
                    end
                end
                scal_pkg::S_OFF: begin
                    if (acth_reg) begin
                        hgain_reg[id_reg] <= gq_reg;
                        hoff_reg[id_reg]  <= off_val;
                    end else begin
                        tgain_reg[id_reg] <= gq_reg;
                        toff_reg[id_reg]  <= off_val;
                    end
                    status_reg <= scal_pkg::ST_OK;
                end
                default: begin
                end
            endcase
            // The averaging sensor clears the count even when it was zero.
            if (state_reg == scal_pkg::S_DECODE && !cmd_reg && sidx_ok && is_avg
                && count_reg == 4'd0) begin
                count_reg <= '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == scal_pkg::S_IDLE && in_valid) begin
            sidx_reg <= sensor_index;
            id_reg   <= command ? cfg_id[IW-1:0] : sensor_index[IW-1:0];
            rt_reg   <= raw_temp;
            rh_reg   <= raw_humi;
            val_reg  <= register_value;
            num_reg  <= command ? 4'd0 : sensor_index;
            tv_reg   <= '0;
            hv_reg   <= '0;
            at_reg   <= '0;
            ah_reg   <= '0;
        end
        if (state_reg == scal_pkg::S_DECODE && cmd_reg && cfg_ok_reg) begin
            num_reg <= 4'(id_reg);
        end
        if (state_reg == scal_pkg::S_DECODE) begin
            sumt_reg <= '0;
            sumh_reg <= '0;
        end
        if (state_reg == scal_pkg::S_SUM && !bad_reg[i_reg]) begin
            sumt_reg <= sumt_reg + SUM_W'(calt_reg[i_reg]);
            sumh_reg <= sumh_reg + SUM_W'(calh_reg[i_reg]);
        end
        if (state_reg == scal_pkg::S_MUL_H) begin
            tv_reg <= cal_val;
        end
        if (state_reg == scal_pkg::S_CAL_H) begin
            hv_reg <= cal_val;
        end
        if (state_reg == scal_pkg::S_DIV_WAIT && div_done) begin
            if (cmd_reg) begin
                gq_reg <= gain_val;
            end else if (hum_reg) begin
                ah_reg <= avg_val;
            end else begin
                at_reg <= avg_val;
            end
        end
        if (state_reg == scal_pkg::S_RD2) begin
            p1_reg <= mem_word;
        end
        if (state_reg == scal_pkg::S_FIT) begin
            fdvd_reg <= DW'(fit_an) + DW'(fit_ad >> 1);
            fdvs_reg <= fit_ad;
            fneg_reg <= fit_dy[16] ^ fit_dx[16];
        end
    end

    // Reference point memory.
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[wr_addr] <= {x_sel, val_reg};
        end
        rd_q_reg <= mem[rd_addr];
        rd_v_reg <= mv_reg[rd_addr];
    end

    assign sensor_number = num_reg;
    assign status        = status_reg;
    assign temp_value    = tv_reg;
    assign humi_value    = hv_reg;
    assign average_valid = av_reg;
    assign average_temp  = at_reg;
    assign average_humi  = ah_reg;

    a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == scal_pkg::S_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_avg_only_avg_sensor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && average_valid) |-> ({1'b0, sensor_number} == 5'(AVG_SENSORS)
                                          && !cmd_reg))
        else $error("average reported for another sensor");

    a_values_zero_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_reg != scal_pkg::ST_OK) |-> (tv_reg == 16'sd0
                                                          && hv_reg == 16'sd0))
        else $error("calibrated values on a failed result");

endmodule

// ===== sim/sensor_two_point_calibrator_test.sv =====
module sensor_two_point_calibrator_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSENS = 10;
    localparam int NAVG  = 8;

    typedef struct packed {
        logic        command;
        logic [3:0]  sensor_index;
        logic [15:0] raw_temp;
        logic [15:0] raw_humi;
        logic [6:0]  register_address;
        logic [15:0] register_value;
    } item_t;

    typedef struct packed {
        logic [3:0]         sensor_number;
        logic [1:0]         status;
        logic signed [15:0] temp_value;
        logic signed [15:0] humi_value;
        logic               average_valid;
        logic signed [15:0] average_temp;
        logic signed [15:0] average_humi;
    } result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic command;
    logic [3:0] sensor_index;
    logic [15:0] raw_temp;
    logic [15:0] raw_humi;
    logic [6:0] register_address;
    logic [15:0] register_value;
    logic out_valid;
    logic out_stall;
    logic [3:0] sensor_number;
    logic [1:0] status;
    logic signed [15:0] temp_value;
    logic signed [15:0] humi_value;
    logic average_valid;
    logic signed [15:0] average_temp;
    logic signed [15:0] average_humi;

    sensor_two_point_calibrator u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .sensor_index(sensor_index),
        .raw_temp(raw_temp), .raw_humi(raw_humi),
        .register_address(register_address), .register_value(register_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .sensor_number(sensor_number), .status(status),
        .temp_value(temp_value), .humi_value(humi_value),
        .average_valid(average_valid),
        .average_temp(average_temp), .average_humi(average_humi)
    );

    // Calibration state mirrored in the testbench.
    logic [15:0] t_gain [NSENS];
    logic [15:0] t_off  [NSENS];
    logic [15:0] h_gain [NSENS];
    logic [15:0] h_off  [NSENS];
    logic [15:0] raw_t_hold [NSENS];
    logic [15:0] raw_h_hold [NSENS];
    logic [15:0] pt_y [NSENS*4];
    logic [15:0] pt_x [NSENS*4];
    logic [15:0] cal_t [NSENS];
    logic [15:0] cal_h [NSENS];
    logic        out_of_range [NSENS];
    int          n_readings;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      error_count;
    int      result_count;
    int      reading_total;
    int      write_total;
    int      average_total;
    bit      sender_hold;
    bit      no_idle;

    function automatic longint clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint round_tie_up(input longint v);
        longint t;
        t = v + 2048;
        if (t >= 0) return t / 4096;
        return -((-t + 4095) / 4096);
    endfunction

    function automatic longint calibrate(input logic [15:0] g, input logic [15:0] o,
                                         input longint raw);
        return clamp16(round_tie_up(longint'($signed(g)) * raw) + longint'($signed(o)));
    endfunction

    // Returns the status of a two-point fit; updates gain and offset on success.
    function automatic logic [1:0] fit_line(input int base, inout logic [15:0] g,
                                            inout logic [15:0] o);
        longint y1, x1, y2, x2, nm, dn, an, ad, q;
        y1 = longint'($signed(pt_y[base]));
        x1 = longint'($signed(pt_x[base]));
        y2 = longint'($signed(pt_y[base+1]));
        x2 = longint'($signed(pt_x[base+1]));
        if (x1 == x2) return scal_pkg::ST_REJECT;
        nm = (y2 - y1) * 4096;
        dn = x2 - x1;
        an = nm < 0 ? -nm : nm;
        ad = dn < 0 ? -dn : dn;
        q = (an + ad / 2) / ad;
        if ((nm < 0) != (dn < 0)) q = -q;
        if (q > 32767 || q < -32768) return scal_pkg::ST_REJECT;
        g = q[15:0];
        o = 16'(clamp16(y1 - round_tie_up(q * x1)));
        return scal_pkg::ST_OK;
    endfunction

    task automatic predict_result(input item_t it);
        result_t r;
        bit tok, hok;
        int grp, slot, id;
        longint st, sh;
        logic [15:0] g, o;
        r = '0;
        r.status = scal_pkg::ST_NONE;
        if (it.command == 1'b0) begin
            r.sensor_number = it.sensor_index;
            if (it.sensor_index < NSENS) begin
                id = it.sensor_index;
                reading_total++;
                tok = (it.raw_temp >= scal_pkg::TEMP_NEG_MIN)
                      || (it.raw_temp <= scal_pkg::TEMP_POS_MAX);
                hok = it.raw_humi <= scal_pkg::HUMI_MAX;
                if (tok) raw_t_hold[id] = it.raw_temp;
                if (tok && hok) begin
                    raw_h_hold[id] = it.raw_humi;
                    r.temp_value = 16'(calibrate(t_gain[id], t_off[id],
                                                 longint'($signed(it.raw_temp))));
                    r.humi_value = 16'(calibrate(h_gain[id], h_off[id],
                                                 longint'(it.raw_humi)));
                    cal_t[id] = r.temp_value;
                    cal_h[id] = r.humi_value;
                    out_of_range[id] = 1'b0;
                    r.status = scal_pkg::ST_OK;
                end else begin
                    out_of_range[id] = 1'b1;
                    r.status = scal_pkg::ST_RANGE;
                end
                if (id < NAVG) begin
                    if (n_readings < 15) n_readings++;
                end else if (id == NAVG) begin
                    if (n_readings != 0) begin
                        st = 0;
                        sh = 0;
                        for (int i = 0; i < NAVG; i++) begin
                            if (!out_of_range[i]) begin
                                st += longint'($signed(cal_t[i]));
                                sh += longint'($signed(cal_h[i]));
                            end
                        end
                        r.average_temp = 16'(clamp16(st / n_readings));
                        r.average_humi = 16'(clamp16(sh / n_readings));
                        r.average_valid = 1'b1;
                        average_total++;
                    end
                    n_readings = 0;
                end
            end
        end else begin
            grp = it.register_address / 5;
            slot = it.register_address % 5;
            if (grp >= 6 && grp - 6 < NSENS) begin
                id = grp - 6;
                write_total++;
                r.sensor_number = 4'(id);
                if (slot < 4) begin
                    pt_y[id*4+slot] = it.register_value;
                    pt_x[id*4+slot] = (slot < 2) ? raw_t_hold[id] : raw_h_hold[id];
                    r.status = scal_pkg::ST_OK;
                end else if (it.register_value == scal_pkg::ACT_FIT_T) begin
                    g = t_gain[id];
                    o = t_off[id];
                    r.status = fit_line(id*4, g, o);
                    t_gain[id] = g;
                    t_off[id] = o;
                end else if (it.register_value == scal_pkg::ACT_FIT_H) begin
                    g = h_gain[id];
                    o = h_off[id];
                    r.status = fit_line(id*4+2, g, o);
                    h_gain[id] = g;
                    h_off[id] = o;
                end else if (it.register_value == scal_pkg::ACT_RST_T) begin
                    t_gain[id] = scal_pkg::GAIN_ONE;
                    t_off[id] = '0;
                    r.status = scal_pkg::ST_OK;
                end else if (it.register_value == scal_pkg::ACT_RST_H) begin
                    h_gain[id] = scal_pkg::GAIN_ONE;
                    h_off[id] = '0;
                    r.status = scal_pkg::ST_OK;
                end
            end
        end
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 result_count, what, got, want);
        error_count++;
    endtask

    // Item builders.
    function automatic item_t reading(input logic [3:0] s, input logic [15:0] t,
                                      input logic [15:0] h);
        item_t it;
        it = item_t'($urandom);
        it.raw_temp = 16'($urandom);
        it.command = 1'b0;
        it.sensor_index = s;
        it.raw_temp = t;
        it.raw_humi = h;
        return it;
    endfunction

    function automatic item_t reg_write(input int sensor, input int slot,
                                        input logic [15:0] v);
        item_t it;
        it = item_t'($urandom);
        it.raw_humi = 16'($urandom);
        it.command = 1'b1;
        it.register_address = 7'((sensor + 6) * 5 + slot);
        it.register_value = v;
        return it;
    endfunction

    function automatic logic [15:0] good_temp();
        return 16'($signed($urandom_range(0, 1000)) - 200);
    endfunction

    function automatic logic [15:0] any_temp();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 16'h0340));
            default: return good_temp();
        endcase
    endfunction

    function automatic logic [15:0] any_humi();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'($urandom_range(16'h03E0, 16'h03F0));
            default: return 16'($urandom_range(0, 1000));
        endcase
    endfunction

    // A reading, a reference write, usually a second reading, a second reference write, then a fit.
    task automatic queue_calibration(input int s);
        bit humi;
        int base;
        humi = 1'($urandom_range(0, 1));
        base = humi ? 2 : 0;
        pending_items.push_back(reading(4'(s), good_temp(), 16'($urandom_range(0, 1000))));
        pending_items.push_back(reg_write(s, base, $urandom_range(0, 3) == 0 ?
                                16'($urandom) : 16'($signed($urandom_range(0, 1200)) - 200)));
        if ($urandom_range(0, 5) != 0)
            pending_items.push_back(reading(4'(s), good_temp(),
                                            16'($urandom_range(0, 1000))));
        pending_items.push_back(reg_write(s, base + 1, $urandom_range(0, 3) == 0 ?
                                16'($urandom) : 16'($signed($urandom_range(0, 1200)) - 200)));
        pending_items.push_back(reg_write(s, 4,
                                          humi ? scal_pkg::ACT_FIT_H : scal_pkg::ACT_FIT_T));
    endtask

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Driver: presents the head of the queue, holds it while stalled, and
    // predicts each item at the edge where it is transferred.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            {command, sensor_index, raw_temp, raw_humi, register_address,
             register_value} <= '0;
        end else begin
            if (!(in_valid && in_stall)) begin
                if (in_valid && !in_stall) predict_result(pending_items.pop_front());
                if (pending_items.size() > 0 && !sender_hold &&
                    (no_idle || $urandom_range(0, 99) >= 13)) begin
                    in_valid <= 1'b1;
                    {command, sensor_index, raw_temp, raw_humi, register_address,
                     register_value} <= pending_items[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge clk or negedge rst_n)
    begin
        result_t w;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", sensor_number, 0);
                end else begin
                    w = expected_results.pop_front();
                    if (sensor_number !== w.sensor_number)
                        report_mismatch("sensor_number", sensor_number, w.sensor_number);
                    if (status !== w.status) report_mismatch("status", status, w.status);
                    if (temp_value !== w.temp_value)
                        report_mismatch("temp_value", temp_value, w.temp_value);
                    if (humi_value !== w.humi_value)
                        report_mismatch("humi_value", humi_value, w.humi_value);
                    if (average_valid !== w.average_valid)
                        report_mismatch("average_valid", average_valid, w.average_valid);
                    if (average_temp !== w.average_temp)
                        report_mismatch("average_temp", average_temp, w.average_temp);
                    if (average_humi !== w.average_humi)
                        report_mismatch("average_humi", average_humi, w.average_humi);
                end
            end
            out_stall <= !no_idle && ($urandom_range(0, 99) < 13);
        end
    end

    initial
    begin
        #50ms;
        $display("[sensor_two_point_calibrator] ERROR");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < NSENS; i++) begin
            t_gain[i] = scal_pkg::GAIN_ONE;
            h_gain[i] = scal_pkg::GAIN_ONE;
            t_off[i] = '0;
            h_off[i] = '0;
            raw_t_hold[i] = '0;
            raw_h_hold[i] = '0;
            cal_t[i] = '0;
            cal_h[i] = '0;
            out_of_range[i] = 1'b0;
        end
        for (int i = 0; i < NSENS*4; i++) begin
            pt_y[i] = '0;
            pt_x[i] = '0;
        end
        n_readings = 0;
        error_count = 0;
        result_count = 0;
        reading_total = 0;
        write_total = 0;
        average_total = 0;
        sender_hold = 1'b0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero-count average, range edges, fits, resets, bad codes.
        pending_items.push_back(reading(4'd8, 16'd0, 16'd0));
        pending_items.push_back(reading(4'd0, scal_pkg::TEMP_NEG_MIN, scal_pkg::HUMI_MAX));
        pending_items.push_back(reading(4'd1, scal_pkg::TEMP_POS_MAX, 16'd0));
        pending_items.push_back(reading(4'd2, scal_pkg::TEMP_NEG_MIN - 16'd1, 16'd5));
        pending_items.push_back(reading(4'd3, scal_pkg::TEMP_POS_MAX + 16'd1, 16'd5));
        pending_items.push_back(reading(4'd4, 16'd100, scal_pkg::HUMI_MAX + 16'd1));
        pending_items.push_back(reading(4'd5, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(reading(4'd8, 16'd50, 16'd50));
        pending_items.push_back(reading(4'd9, 16'd1, 16'd2));
        pending_items.push_back(reading(4'd15, 16'd1, 16'd2));
        pending_items.push_back(reg_write(0, 4, scal_pkg::ACT_FIT_T));
        pending_items.push_back(reg_write(0, 0, 16'd10));
        pending_items.push_back(reading(4'd0, 16'd100, 16'd200));
        pending_items.push_back(reg_write(0, 1, 16'h7FFF));
        pending_items.push_back(reg_write(0, 4, scal_pkg::ACT_FIT_T));
        pending_items.push_back(reading(4'd0, 16'd101, 16'd201));
        pending_items.push_back(reg_write(0, 1, 16'h8000));
        pending_items.push_back(reg_write(0, 4, scal_pkg::ACT_FIT_T));
        pending_items.push_back(reg_write(0, 4, scal_pkg::ACT_FIT_H));
        pending_items.push_back(reg_write(0, 4, scal_pkg::ACT_RST_T));
        pending_items.push_back(reg_write(0, 4, scal_pkg::ACT_RST_H));
        pending_items.push_back(reg_write(9, 4, 16'd0));
        pending_items.push_back(reg_write(9, 4, 16'hFFFF));
        begin
            item_t it;
            it = reg_write(0, 0, 16'd1);
            it.register_address = 7'd29;
            pending_items.push_back(it);
            it.register_address = 7'd127;
            pending_items.push_back(it);
        end

        // Hold the sender until the directed part has fully drained.
        wait (pending_items.size() == 0);
        sender_hold = 1'b1;
        wait (expected_results.size() == 0);
        sender_hold = 1'b0;

        for (int n = 0; n < 800; )
        begin
            item_t it;
            int k;
            k = $urandom_range(0, 99);
            if (k < 40) begin
                queue_calibration($urandom_range(0, NSENS - 1));
                n += 5;
            end else if (k < 70) begin
                pending_items.push_back(reading(4'($urandom_range(0, 9)), any_temp(),
                                                any_humi()));
                n++;
            end else if (k < 78) begin
                pending_items.push_back(reading(4'd8, any_temp(), any_humi()));
                n++;
            end else if (k < 88) begin
                pending_items.push_back(reg_write($urandom_range(0, 9), 4,
                                                  16'($urandom_range(0, 5))));
                n++;
            end else begin
                it = item_t'({$urandom, $urandom, $urandom});
                pending_items.push_back(it);
                n++;
            end
            if (n >= 300 && n < 306) no_idle = 1'b1;
            if (n >= 450 && n < 456) no_idle = 1'b0;
            while (pending_items.size() > 20) @(posedge clk);
        end

        wait (pending_items.size() == 0);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);
        $display("covered %0d readings, %0d calibration writes, %0d averages, %0d results",
                 reading_total, write_total, average_total, result_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[sensor_two_point_calibrator] OK");
        end else begin
            $display("[sensor_two_point_calibrator] ERROR");
        end
        $finish;
    end

endmodule

// ===== sensor_two_point_calibrator.f =====
sv/scal_pkg.sv
sv/scal_mul.sv
sv/scal_div.sv
sv/sensor_two_point_calibrator.sv
sim/sensor_two_point_calibrator_test.sv
